// ----- sv/single_source_shortest_path_macros.svh -----
// assertion macros shared by the shortest path block
`ifndef SINGLE_SOURCE_SHORTEST_PATH_MACROS_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_MACROS_SVH

// same-cycle implication
`define SSSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SSSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/sssp_pkg.sv -----
// types and constants shared by the shortest path controller and datapath
package sssp_pkg;

  localparam int VID_W    = 5;
  localparam int DIST_W   = 32;
  localparam int WEIGHT_W = 16;
  localparam int CFG_W    = 6;

  localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = 6'd32;

  localparam logic REG_VERTEX_COUNT  = 1'b0;
  localparam logic REG_SOURCE_VERTEX = 1'b1;

  localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7fff_ffff;
  localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_FETCH,
    ST_LOOKUP,
    ST_ADD,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INIT,
    OP_FETCH,
    OP_LOOKUP,
    OP_ADD,
    OP_RELAX,
    OP_CHECK,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load;
    logic clear_flag;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic cycle_found;
  } status_t;

  typedef struct packed {
    logic [VID_W-1:0]           from_v;
    logic [VID_W-1:0]           to_v;
    logic signed [WEIGHT_W-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic                     dvalid;
    logic signed [DIST_W-1:0] cost;
    logic                     pvalid;
    logic [VID_W-1:0]         pred;
  } vertex_t;

endpackage

// ----- sv/sssp_ctrl.sv -----
// sequencing state machine: edge load, init sweep, relax passes, check pass, emit
`include "single_source_shortest_path_macros.svh"

module sssp_ctrl #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 256,
  parameter int VW           = $clog2(MAX_VERTICES),
  parameter int NW           = $clog2(MAX_VERTICES + 1),
  parameter int EW           = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              last_edge,
  input  logic [NW-1:0]     n,
  input  sssp_pkg::status_t status,
  output logic              busy,
  output logic [EW-1:0]     edge_addr,
  output logic [VW-1:0]     vertex_addr,
  output sssp_pkg::cmd_t    cmd
);
  import sssp_pkg::*;

  localparam int CW = $clog2(MAX_EDGES + 1);

  state_t        state, state_next;
  logic [VW-1:0] v, v_next;
  logic [CW-1:0] k, k_next;
  logic [CW-1:0] edge_count, edge_count_next;
  logic [NW-1:0] pass, pass_next;
  logic          check, check_next;
  logic          v_last;
  logic          k_last;

  assign v_last = (NW'(v) == n - 1'b1);
  assign k_last = (k == edge_count - 1'b1);
  assign busy   = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      v          <= '0;
      k          <= '0;
      edge_count <= '0;
      pass       <= '0;
      check      <= 1'b0;
    end else begin
      state      <= state_next;
      v          <= v_next;
      k          <= k_next;
      edge_count <= edge_count_next;
      pass       <= pass_next;
      check      <= check_next;
    end
  end

  always_comb begin
    state_next      = state;
    v_next          = v;
    k_next          = k;
    edge_count_next = edge_count;
    pass_next       = pass;
    check_next      = check;
    cmd             = '{op: OP_NONE, load: 1'b0, clear_flag: 1'b0, last: 1'b0};
    edge_addr       = k[EW-1:0];
    vertex_addr     = v;
    case (state)
      ST_IDLE: begin
        edge_addr = edge_count[EW-1:0];
        if (start) begin
          if (edge_count < CW'(MAX_EDGES)) begin
            cmd.load        = 1'b1;
            edge_count_next = edge_count + 1'b1;
          end
          if (last_edge) begin
            state_next = ST_INIT;
            v_next     = '0;
          end
        end
      end
      ST_INIT: begin
        cmd.op         = OP_INIT;
        cmd.clear_flag = 1'b1;
        if (v_last) begin
          k_next     = '0;
          pass_next  = NW'(1);
          check_next = (n == NW'(1));
          state_next = ST_FETCH;
        end else begin
          v_next = v + 1'b1;
        end
      end
      ST_FETCH: begin
        if (check && status.cycle_found) begin
          v_next     = '0;
          state_next = ST_EMIT;
        end else begin
          cmd.op     = OP_FETCH;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.op     = OP_LOOKUP;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.op     = OP_ADD;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.op = check ? OP_CHECK : OP_RELAX;
        if (k_last) begin
          k_next = '0;
          if (check) begin
            v_next     = '0;
            state_next = ST_EMIT;
          end else if (pass == n - 1'b1) begin
            check_next = 1'b1;
            state_next = ST_FETCH;
          end else begin
            pass_next  = pass + 1'b1;
            state_next = ST_FETCH;
          end
        end else begin
          k_next     = k + 1'b1;
          state_next = ST_FETCH;
        end
      end
      ST_EMIT: begin
        cmd.op   = OP_EMIT;
        cmd.last = v_last;
        if (v_last) begin
          edge_count_next = '0;
          state_next      = ST_IDLE;
        end else begin
          v_next = v + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `SSSP_ASSERT_NOW(a_edge_in_range, (state == ST_FETCH || state == ST_LOOKUP || state == ST_ADD || state == ST_UPDATE), (k < edge_count), "edge index past loaded edges")
  `SSSP_ASSERT_NOW(a_vertex_in_range, (state == ST_INIT || state == ST_EMIT), (NW'(v) < n), "vertex index past vertex count")
  `SSSP_ASSERT_NOW(a_pass_bound, (state == ST_UPDATE && !check), (pass != '0 && pass < n), "relax pass out of range")
  `SSSP_ASSERT_NEXT(a_emit_done, (state == ST_EMIT && v_last), (state == ST_IDLE && edge_count == '0), "run did not finish after last result")

endmodule

// ----- sv/sssp_datapath.sv -----
// edge store, vertex store, saturating relax arithmetic and result registers
module sssp_datapath #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 256,
  parameter int VW           = $clog2(MAX_VERTICES),
  parameter int NW           = $clog2(MAX_VERTICES + 1),
  parameter int EW           = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  sssp_pkg::cmd_t                          cmd,
  output sssp_pkg::status_t                       status,
  input  logic [EW-1:0]                           edge_addr,
  input  logic [VW-1:0]                           vertex_addr,
  input  logic [NW-1:0]                           n,
  input  logic [sssp_pkg::VID_W-1:0]              source_vertex,
  input  logic [sssp_pkg::VID_W-1:0]              edge_source,
  input  logic [sssp_pkg::VID_W-1:0]              edge_dest,
  input  logic signed [sssp_pkg::WEIGHT_W-1:0]    edge_weight,
  output logic                                    result_valid,
  output logic [sssp_pkg::VID_W-1:0]              vertex_index,
  output logic signed [sssp_pkg::DIST_W-1:0]      distance,
  output logic                                    reachable,
  output logic [sssp_pkg::VID_W-1:0]              predecessor,
  output logic                                    has_predecessor,
  output logic                                    negative_cycle,
  output logic                                    last_vertex
);
  import sssp_pkg::*;

  localparam int IXW = 7;

  edge_t   edge_mem   [MAX_EDGES];
  vertex_t vertex_mem [MAX_VERTICES];

  edge_t                    edge_q;
  vertex_t                  a_q;
  vertex_t                  b_q;
  logic signed [DIST_W-1:0] cand_q;
  logic                     ok_q;
  logic                     in_range_q;
  logic                     cycle_flag;
  logic [VID_W-1:0]         index_q;
  logic                     last_q;

  logic [IXW-1:0]           from_wide, to_wide, addr_wide;
  logic [VW-1:0]            from_ix, to_ix, port_a_addr;
  logic                     is_source;
  logic signed [DIST_W:0]   sum;
  logic signed [DIST_W-1:0] sat;
  logic                     improve;

  assign from_wide   = IXW'(edge_q.from_v);
  assign to_wide     = IXW'(edge_q.to_v);
  assign addr_wide   = IXW'(vertex_addr);
  assign from_ix     = from_wide[VW-1:0];
  assign to_ix       = to_wide[VW-1:0];
  assign port_a_addr = (cmd.op == OP_EMIT) ? vertex_addr : from_ix;
  assign is_source   = (addr_wide == IXW'(source_vertex));

  assign sum = {a_q.cost[DIST_W-1], a_q.cost}
             + {{(DIST_W + 1 - WEIGHT_W){edge_q.weight[WEIGHT_W-1]}}, edge_q.weight};

  always_comb begin
    if (sum[DIST_W] != sum[DIST_W-1]) begin
      sat = sum[DIST_W] ? DIST_MIN : DIST_MAX;
    end else begin
      sat = sum[DIST_W-1:0];
    end
  end

  assign improve = ok_q && (!b_q.dvalid || ($signed(b_q.cost) > $signed(cand_q)));

  // edge store
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      edge_mem[edge_addr] <= '{from_v: edge_source, to_v: edge_dest, weight: edge_weight};
    end
    if (cmd.op == OP_FETCH) begin
      edge_q <= edge_mem[edge_addr];
    end
  end

  // vertex store: one write port, two read ports
  always_ff @(posedge clk) begin
    if (cmd.op == OP_INIT) begin
      vertex_mem[vertex_addr] <= '{dvalid: is_source, cost: '0, pvalid: 1'b0, pred: '0};
    end else if (cmd.op == OP_RELAX && improve) begin
      vertex_mem[to_ix] <= '{dvalid: 1'b1, cost: cand_q, pvalid: 1'b1, pred: edge_q.from_v};
    end
    if (cmd.op == OP_LOOKUP || cmd.op == OP_EMIT) begin
      a_q <= vertex_mem[port_a_addr];
    end
    if (cmd.op == OP_LOOKUP) begin
      b_q <= vertex_mem[to_ix];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOOKUP) begin
      in_range_q <= (from_wide < IXW'(n)) && (to_wide < IXW'(n));
    end
    if (cmd.op == OP_ADD) begin
      cand_q <= sat;
      ok_q   <= in_range_q && a_q.dvalid;
    end
    if (cmd.op == OP_EMIT) begin
      index_q <= addr_wide[VID_W-1:0];
      last_q  <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_flag   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.op == OP_EMIT);
      if (cmd.clear_flag) begin
        cycle_flag <= 1'b0;
      end else if (cmd.op == OP_CHECK && improve) begin
        cycle_flag <= 1'b1;
      end
    end
  end

  assign status.cycle_found = cycle_flag;

  assign vertex_index    = index_q;
  assign distance        = a_q.dvalid ? a_q.cost : '0;
  assign reachable       = a_q.dvalid;
  assign predecessor     = a_q.pvalid ? a_q.pred : '0;
  assign has_predecessor = a_q.pvalid;
  assign negative_cycle  = cycle_flag;
  assign last_vertex     = last_q;

endmodule

// ----- sv/single_source_shortest_path.sv -----
// edges load back to back with start high in idle, up to MAX_EDGES; the marked
// last edge starts a run: an init sweep over the n vertices, n-1 relax passes
// and one check pass, each edge going through fetch, lookup, add and update,
// then n results in a row; the check pass stops at the first improvable edge
// busy is high from the last edge until the final result; start is ignored then
// synchronous reset clears the control state, the edge count and the flags
module single_source_shortest_path #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [sssp_pkg::CFG_W-1:0]           cfg_data,
  input  logic [sssp_pkg::VID_W-1:0]           edge_source,
  input  logic [sssp_pkg::VID_W-1:0]           edge_dest,
  input  logic signed [sssp_pkg::WEIGHT_W-1:0] edge_weight,
  input  logic                                 last_edge,
  output logic                                 result_valid,
  output logic [sssp_pkg::VID_W-1:0]           vertex_index,
  output logic signed [sssp_pkg::DIST_W-1:0]   distance,
  output logic                                 reachable,
  output logic [sssp_pkg::VID_W-1:0]           predecessor,
  output logic                                 has_predecessor,
  output logic                                 negative_cycle,
  output logic                                 last_vertex
);
  import sssp_pkg::*;

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CMW = 7;

  logic [CFG_W-1:0] vertex_count;
  logic [VID_W-1:0] source_vertex;
  logic [CMW-1:0]   n_wide;
  logic [NW-1:0]    n;
  logic [EW-1:0]    edge_addr;
  logic [VW-1:0]    vertex_addr;
  cmd_t             cmd;
  status_t          status;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= VERTEX_COUNT_RESET;
      source_vertex <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VERTEX_COUNT:  vertex_count  <= cfg_data;
        REG_SOURCE_VERTEX: source_vertex <= cfg_data[VID_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // clamp the vertex count to 1 .. MAX_VERTICES
  always_comb begin
    if (vertex_count == '0) begin
      n_wide = CMW'(1);
    end else if (CMW'(vertex_count) > CMW'(MAX_VERTICES)) begin
      n_wide = CMW'(MAX_VERTICES);
    end else begin
      n_wide = CMW'(vertex_count);
    end
  end
  assign n = n_wide[NW-1:0];

  sssp_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .VW           (VW),
    .NW           (NW),
    .EW           (EW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .last_edge   (last_edge),
    .n           (n),
    .status      (status),
    .busy        (busy),
    .edge_addr   (edge_addr),
    .vertex_addr (vertex_addr),
    .cmd         (cmd)
  );

  sssp_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .VW           (VW),
    .NW           (NW),
    .EW           (EW)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .edge_addr       (edge_addr),
    .vertex_addr     (vertex_addr),
    .n               (n),
    .source_vertex   (source_vertex),
    .edge_source     (edge_source),
    .edge_dest       (edge_dest),
    .edge_weight     (edge_weight),
    .result_valid    (result_valid),
    .vertex_index    (vertex_index),
    .distance        (distance),
    .reachable       (reachable),
    .predecessor     (predecessor),
    .has_predecessor (has_predecessor),
    .negative_cycle  (negative_cycle),
    .last_vertex     (last_vertex)
  );

endmodule
